### rtl/kdrl_pkg.sv
// kdrl_pkg: shared types and constants for the key debounce / repeat / long press block
// holds register index codes, reset values and the timing register struct
// no dependencies
`default_nettype none

package kdrl_pkg;

	// default parameter values
	localparam int NUM_KEYS_DEF    = 3;
	localparam int TIMER_WIDTH_DEF = 16;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MASK_W     = 3;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] LOCKOUT_RST      = 16'd80;
	localparam logic [CFG_DATA_W-1:0] CONFIRM_RST      = 16'd20;
	localparam logic [CFG_DATA_W-1:0] REPEAT_START_RST = 16'd450;
	localparam logic [CFG_DATA_W-1:0] REPEAT_INT_RST   = 16'd120;
	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 16'd1200;
	localparam logic [MASK_W-1:0]     REPEAT_MASK_RST  = 3'd5;
	localparam logic [MASK_W-1:0]     RELEASE_MASK_RST = 3'd2;

	// register index codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCKOUT      = 3'd0,
		CFG_CONFIRM      = 3'd1,
		CFG_REPEAT_START = 3'd2,
		CFG_REPEAT_INT   = 3'd3,
		CFG_LONG_PRESS   = 3'd4,
		CFG_REPEAT_MASK  = 3'd5,
		CFG_RELEASE_MASK = 3'd6
	} cfg_idx_t;

	// timing registers handed to every lane
	typedef struct packed {
		logic [CFG_DATA_W-1:0] lockout;
		logic [CFG_DATA_W-1:0] confirm;
		logic [CFG_DATA_W-1:0] repeat_start;
		logic [CFG_DATA_W-1:0] repeat_int;
		logic [CFG_DATA_W-1:0] long_press;
	} timing_t;

endpackage

`default_nettype wire

### rtl/kdrl_cfg_regs.sv
// kdrl_cfg_regs: configuration register file written through the cfg channel
// depends on kdrl_pkg (index codes, reset values, timing_t)
`default_nettype none

module kdrl_cfg_regs #(
	parameter int NUM_KEYS = kdrl_pkg::NUM_KEYS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [kdrl_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  wire logic [kdrl_pkg::CFG_DATA_W-1:0] wr_data,
	output kdrl_pkg::timing_t                    timing,
	output logic [NUM_KEYS-1:0]                  repeat_mask,
	output logic [NUM_KEYS-1:0]                  release_mask
);

	kdrl_pkg::timing_t   timing_q;
	logic [NUM_KEYS-1:0] repeat_mask_q;
	logic [NUM_KEYS-1:0] release_mask_q;
	logic [NUM_KEYS-1:0] data_mask;
	logic [NUM_KEYS-1:0] repeat_rst;
	logic [NUM_KEYS-1:0] release_rst;

	// only the low mask bits of a word reach the per-key masks
	always_comb begin
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (i < kdrl_pkg::MASK_W) begin
				data_mask[i]   = wr_data[i];
				repeat_rst[i]  = kdrl_pkg::REPEAT_MASK_RST[i];
				release_rst[i] = kdrl_pkg::RELEASE_MASK_RST[i];
			end else begin
				data_mask[i]   = 1'b0;
				repeat_rst[i]  = 1'b0;
				release_rst[i] = 1'b0;
			end
		end
	end

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.lockout      <= kdrl_pkg::LOCKOUT_RST;
			timing_q.confirm      <= kdrl_pkg::CONFIRM_RST;
			timing_q.repeat_start <= kdrl_pkg::REPEAT_START_RST;
			timing_q.repeat_int   <= kdrl_pkg::REPEAT_INT_RST;
			timing_q.long_press   <= kdrl_pkg::LONG_PRESS_RST;
			repeat_mask_q         <= repeat_rst;
			release_mask_q        <= release_rst;
		end else if (wr_en) begin
			unique case (wr_idx)
				kdrl_pkg::CFG_LOCKOUT:      timing_q.lockout      <= wr_data;
				kdrl_pkg::CFG_CONFIRM:      timing_q.confirm      <= wr_data;
				kdrl_pkg::CFG_REPEAT_START: timing_q.repeat_start <= wr_data;
				kdrl_pkg::CFG_REPEAT_INT:   timing_q.repeat_int   <= wr_data;
				kdrl_pkg::CFG_LONG_PRESS:   timing_q.long_press   <= wr_data;
				kdrl_pkg::CFG_REPEAT_MASK:  repeat_mask_q         <= data_mask;
				kdrl_pkg::CFG_RELEASE_MASK: release_mask_q        <= data_mask;
				default: ;
			endcase
		end
	end

	assign timing       = timing_q;
	assign repeat_mask  = repeat_mask_q;
	assign release_mask = release_mask_q;

endmodule

`default_nettype wire

### rtl/kdrl_key_lane.sv
// kdrl_key_lane: debounce, lockout, auto repeat and release for one ordinary key
// one lane per key; depends on kdrl_pkg (timing_t)
`default_nettype none

module kdrl_key_lane #(
	parameter int TIMER_WIDTH = kdrl_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             level,
	input  wire kdrl_pkg::timing_t timing,
	input  wire logic             rep_en,
	input  wire logic             rel_en,
	output logic                  press_evt,
	output logic                  rel_evt
);

	localparam int CW = (TIMER_WIDTH > kdrl_pkg::CFG_DATA_W) ? TIMER_WIDTH
	                                                         : kdrl_pkg::CFG_DATA_W;

	typedef enum logic [2:0] {
		KP_IDLE        = 3'd0,
		KP_CONFIRM     = 3'd1,
		KP_REP_WAIT    = 3'd2,
		KP_REP_RUN     = 3'd3,
		KP_REL_CONFIRM = 3'd4
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d, timer_inc;
	logic [TIMER_WIDTH-1:0] since_q, since_d, since_inc;
	logic                   prev_q;
	logic [CW-1:0]          limit;
	logic                   period_done;
	logic                   lockout_ok;

	// saturating increments
	assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
	assign since_inc = (since_q == '1) ? since_q : since_q + 1'b1;

	// period limit for the running phase
	always_comb begin
		case (phase_q)
			KP_REP_WAIT: limit = CW'(timing.repeat_start);
			KP_REP_RUN:  limit = CW'(timing.repeat_int);
			default:     limit = CW'(timing.confirm);
		endcase
	end

	assign period_done = CW'(timer_inc) >= limit;
	assign lockout_ok  = CW'(since_inc) >= CW'(timing.lockout);

	// next state and events
	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		since_d   = since_inc;
		press_evt = 1'b0;
		rel_evt   = 1'b0;
		unique case (phase_q) inside
			KP_CONFIRM: begin
				timer_d = timer_inc;
				if (period_done) begin
					timer_d = '0;
					phase_d = KP_IDLE;
					if (!level) begin
						press_evt = 1'b1;
						since_d   = '0;
						if (rep_en) begin
							phase_d = KP_REP_WAIT;
						end
					end
				end
			end
			KP_REP_WAIT, KP_REP_RUN: begin
				timer_d = timer_inc;
				if (period_done) begin
					timer_d = '0;
					if (!level) begin
						press_evt = 1'b1;
						phase_d   = KP_REP_RUN;
					end else begin
						since_d = '0;
						phase_d = rel_en ? KP_REL_CONFIRM : KP_IDLE;
					end
				end
			end
			KP_REL_CONFIRM: begin
				timer_d = timer_inc;
				if (period_done) begin
					timer_d = '0;
					rel_evt = level;
					phase_d = KP_IDLE;
				end
			end
			default: begin
				phase_d = KP_IDLE;
				if (prev_q && !level) begin
					if (lockout_ok) begin
						phase_d = KP_CONFIRM;
						timer_d = '0;
					end
				end else if (!prev_q && level) begin
					if (rel_en) begin
						phase_d = KP_REL_CONFIRM;
						timer_d = '0;
					end
				end
			end
		endcase
	end

	// lane state, moves once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= KP_IDLE;
			timer_q <= '0;
			since_q <= '1;
			prev_q  <= 1'b1;
		end else if (advance) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			since_q <= since_d;
			prev_q  <= level;
		end
	end

endmodule

`default_nettype wire

### rtl/kdrl_power_lane.sv
// kdrl_power_lane: power key debounce with short and long press detection
// depends on kdrl_pkg (timing_t)
`default_nettype none

module kdrl_power_lane #(
	parameter int TIMER_WIDTH = kdrl_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             level,
	input  wire kdrl_pkg::timing_t timing,
	output logic                  short_evt,
	output logic                  long_evt
);

	localparam int CW = (TIMER_WIDTH > kdrl_pkg::CFG_DATA_W) ? TIMER_WIDTH
	                                                         : kdrl_pkg::CFG_DATA_W;

	typedef enum logic [2:0] {
		PP_WAIT_RELEASE = 3'd0,
		PP_GUARD        = 3'd1,
		PP_IDLE         = 3'd2,
		PP_DEB_PRESS    = 3'd3,
		PP_HELD         = 3'd4,
		PP_DEB_RELEASE  = 3'd5
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d, timer_inc;
	logic                   long_sent_q, long_sent_d;
	logic                   deb_done;
	logic                   hold_done;

	assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
	assign deb_done  = CW'(timer_inc) >= CW'(timing.lockout);
	assign hold_done = CW'(timer_inc) >= CW'(timing.long_press);

	// next state and events
	always_comb begin
		phase_d     = phase_q;
		timer_d     = timer_q;
		long_sent_d = long_sent_q;
		short_evt   = 1'b0;
		long_evt    = 1'b0;
		unique case (phase_q)
			PP_GUARD: begin
				timer_d = timer_inc;
				if (deb_done) begin
					timer_d = '0;
					phase_d = PP_IDLE;
				end
			end
			PP_IDLE: begin
				if (!level) begin
					timer_d = '0;
					phase_d = PP_DEB_PRESS;
				end
			end
			PP_DEB_PRESS: begin
				timer_d = timer_inc;
				if (deb_done) begin
					timer_d = '0;
					if (!level) begin
						long_sent_d = 1'b0;
						phase_d     = PP_HELD;
					end else begin
						phase_d = PP_IDLE;
					end
				end
			end
			PP_HELD: begin
				if (level) begin
					timer_d = '0;
					phase_d = PP_DEB_RELEASE;
				end else begin
					timer_d = timer_inc;
					if (hold_done && !long_sent_q) begin
						long_evt    = 1'b1;
						long_sent_d = 1'b1;
					end
				end
			end
			PP_DEB_RELEASE: begin
				timer_d = timer_inc;
				if (deb_done) begin
					timer_d   = '0;
					short_evt = !long_sent_q;
					phase_d   = PP_IDLE;
				end
			end
			default: begin
				phase_d = PP_WAIT_RELEASE;
				if (level) begin
					timer_d = '0;
					phase_d = PP_GUARD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PP_WAIT_RELEASE;
			timer_q     <= '0;
			long_sent_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			timer_q     <= timer_d;
			long_sent_q <= long_sent_d;
		end
	end

endmodule

`default_nettype wire

### rtl/key_debounce_repeat_longpress.sv
// key_debounce_repeat_longpress: top level, one lane per key plus the power lane
// depends on kdrl_pkg, kdrl_cfg_regs, kdrl_key_lane, kdrl_power_lane
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | key_levels, power_level (one tick)
//   out     | out_valid / out_ready| press_events, release_events, power_short,
//           |                      | power_long
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word per cycle while the output is not stalled: every lane updates in the cycle its tick
// is accepted, and the merged events are captured in a single output register as it is accepted.
// in_ready drops only while the output register is full and out_ready is low.
// cfg_ready is always high; a write takes effect on the next accepted tick.
// reset clears all lane state to idle, the power key to waiting for release.
`default_nettype none

module key_debounce_repeat_longpress #(
	parameter int NUM_KEYS    = kdrl_pkg::NUM_KEYS_DEF,
	parameter int TIMER_WIDTH = kdrl_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [NUM_KEYS-1:0]             key_levels,
	input  wire logic                            power_level,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [NUM_KEYS-1:0]                  press_events,
	output logic [NUM_KEYS-1:0]                  release_events,
	output logic                                 power_short,
	output logic                                 power_long,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [kdrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kdrl_pkg::CFG_DATA_W-1:0] cfg_data
);

	kdrl_pkg::timing_t   timing;
	logic [NUM_KEYS-1:0] repeat_mask;
	logic [NUM_KEYS-1:0] release_mask;
	logic                advance;
	logic [NUM_KEYS-1:0] press_evt;
	logic [NUM_KEYS-1:0] rel_evt;
	logic                short_evt;
	logic                long_evt;
	logic                out_valid_q;
	logic [NUM_KEYS-1:0] press_q;
	logic [NUM_KEYS-1:0] release_q;
	logic                short_q;
	logic                long_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign advance   = in_valid && in_ready;

	// configuration registers
	kdrl_cfg_regs #(
		.NUM_KEYS(NUM_KEYS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (cfg_valid && cfg_ready),
		.wr_idx      (cfg_index),
		.wr_data     (cfg_data),
		.timing      (timing),
		.repeat_mask (repeat_mask),
		.release_mask(release_mask)
	);

	// one lane per ordinary key
	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
		kdrl_key_lane #(
			.TIMER_WIDTH(TIMER_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.level    (key_levels[g]),
			.timing   (timing),
			.rep_en   (repeat_mask[g]),
			.rel_en   (release_mask[g]),
			.press_evt(press_evt[g]),
			.rel_evt  (rel_evt[g])
		);
	end

	// power key lane
	kdrl_power_lane #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_power (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.level    (power_level),
		.timing   (timing),
		.short_evt(short_evt),
		.long_evt (long_evt)
	);

	// merge stage: output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			press_q   <= press_evt;
			release_q <= rel_evt;
			short_q   <= short_evt;
			long_q    <= long_evt;
		end
	end

	assign out_valid      = out_valid_q;
	assign press_events   = press_q;
	assign release_events = release_q;
	assign power_short    = short_q;
	assign power_long     = long_q;

	// an empty output register never holds off the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

	// every accepted tick yields a word next cycle
	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("accepted tick produced no word");

	// a key never presses and releases in the same tick
	a_press_xor_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((press_q & release_q) == '0))
		else $error("press and release on the same key");

	// short and long power events are exclusive
	a_power_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(short_q && long_q))
		else $error("short and long power events together");

endmodule

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for key_debounce_repeat_longpress
// drives tick words, register writes and output stalls; checks every result word
// depends on kdrl_pkg and the rtl top level
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 60;
	// index past the end of the register list, writes must be dropped
	localparam logic [kdrl_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;

	typedef enum logic [2:0] {
		K_IDLE = 3'd0,
		K_CONFIRM = 3'd1,
		K_REP_WAIT = 3'd2,
		K_REP_RUN = 3'd3,
		K_REL_CONFIRM = 3'd4
	} key_stage_t;

	typedef enum logic [2:0] {
		P_WAIT_REL = 3'd0,
		P_GUARD = 3'd1,
		P_IDLE = 3'd2,
		P_DEB_PRESS = 3'd3,
		P_HELD = 3'd4,
		P_DEB_REL = 3'd5
	} power_stage_t;

	typedef struct packed {
		logic [2:0] press;
		logic [2:0] rel;
		logic       pshort;
		logic       plong;
	} event_word_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [kdrl_pkg::CFG_IDX_W-1:0]  idx;
		logic [kdrl_pkg::CFG_DATA_W-1:0] data;
		logic [2:0]                      keys;
		logic                            pwr;
		logic                            typed;
		event_word_t                     want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] key_levels = 3'b111;
	logic power_level = 1'b1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] press_events;
	logic [2:0] release_events;
	logic power_short;
	logic power_long;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [kdrl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [kdrl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	key_debounce_repeat_longpress dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key_levels(key_levels),
		.power_level(power_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.press_events(press_events),
		.release_events(release_events),
		.power_short(power_short),
		.power_long(power_long),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow registers and key state of the debouncer
	kdrl_pkg::timing_t tmg;
	logic [2:0] rep_en;
	logic [2:0] rel_en;
	key_stage_t key_stage[3];
	logic [15:0] key_count[3];
	logic [15:0] press_age[3];
	logic key_last[3];
	power_stage_t pwr_stage;
	logic [15:0] pwr_count;
	logic long_fired;

	event_word_t event_q[$];
	dir_row_t dir_rows[$];
	int errors = 0;
	int words_seen = 0;

	// level generator state
	logic [2:0] lvl_now = 3'b111;
	logic pwr_now = 1'b1;
	int key_hold[3] = '{0, 0, 0};
	int pwr_hold = 0;

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hffff) ? v : v + 16'd1;
	endfunction

	// one tick of all key lanes and the power lane, returns the event word
	function automatic event_word_t debounce_tick(input logic [2:0] lv, input logic pl);
		event_word_t r;
		logic [15:0] lim;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			press_age[i] = bump(press_age[i]);
			case (key_stage[i]) inside
			K_CONFIRM: begin
				key_count[i] = bump(key_count[i]);
				if (key_count[i] >= tmg.confirm) begin
					key_count[i] = '0;
					if (!lv[i]) begin
						r.press[i] = 1'b1;
						press_age[i] = '0;
						key_stage[i] = rep_en[i] ? K_REP_WAIT : K_IDLE;
					end else begin
						key_stage[i] = K_IDLE;
					end
				end
			end
			K_REP_WAIT, K_REP_RUN: begin
				lim = (key_stage[i] == K_REP_WAIT) ? tmg.repeat_start : tmg.repeat_int;
				key_count[i] = bump(key_count[i]);
				if (key_count[i] >= lim) begin
					key_count[i] = '0;
					if (!lv[i]) begin
						r.press[i] = 1'b1;
						key_stage[i] = K_REP_RUN;
					end else begin
						// lockout restarts on the release
						press_age[i] = '0;
						key_stage[i] = rel_en[i] ? K_REL_CONFIRM : K_IDLE;
					end
				end
			end
			K_REL_CONFIRM: begin
				key_count[i] = bump(key_count[i]);
				if (key_count[i] >= tmg.confirm) begin
					key_count[i] = '0;
					if (lv[i])
						r.rel[i] = 1'b1;
					key_stage[i] = K_IDLE;
				end
			end
			default: begin
				key_stage[i] = K_IDLE;
				if (key_last[i] && !lv[i]) begin
					if (press_age[i] >= tmg.lockout) begin
						key_stage[i] = K_CONFIRM;
						key_count[i] = '0;
					end
				end else if (!key_last[i] && lv[i] && rel_en[i]) begin
					key_stage[i] = K_REL_CONFIRM;
					key_count[i] = '0;
				end
			end
			endcase
			key_last[i] = lv[i];
		end

		// power key lane
		case (pwr_stage)
		P_GUARD: begin
			pwr_count = bump(pwr_count);
			if (pwr_count >= tmg.lockout) begin
				pwr_count = '0;
				pwr_stage = P_IDLE;
			end
		end
		P_IDLE: begin
			if (!pl) begin
				pwr_count = '0;
				pwr_stage = P_DEB_PRESS;
			end
		end
		P_DEB_PRESS: begin
			pwr_count = bump(pwr_count);
			if (pwr_count >= tmg.lockout) begin
				pwr_count = '0;
				if (!pl) begin
					long_fired = 1'b0;
					pwr_stage = P_HELD;
				end else begin
					pwr_stage = P_IDLE;
				end
			end
		end
		P_HELD: begin
			if (pl) begin
				pwr_count = '0;
				pwr_stage = P_DEB_REL;
			end else begin
				pwr_count = bump(pwr_count);
				if (pwr_count >= tmg.long_press && !long_fired) begin
					r.plong = 1'b1;
					long_fired = 1'b1;
				end
			end
		end
		P_DEB_REL: begin
			// level is not looked at again when the release debounce ends
			pwr_count = bump(pwr_count);
			if (pwr_count >= tmg.lockout) begin
				pwr_count = '0;
				if (!long_fired)
					r.pshort = 1'b1;
				pwr_stage = P_IDLE;
			end
		end
		default: begin
			pwr_stage = P_WAIT_REL;
			if (pl) begin
				pwr_count = '0;
				pwr_stage = P_GUARD;
			end
		end
		endcase
		return r;
	endfunction

	function automatic int hold_len(input int span);
		// short bounces mixed into held levels
		return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(1, span);
	endfunction

	// next raw levels: each key holds a level for a random number of ticks
	function automatic void advance_levels(input int span);
		for (int i = 0; i < 3; i++) begin
			if (key_hold[i] == 0) begin
				lvl_now[i] = ~lvl_now[i];
				key_hold[i] = hold_len(span);
			end
			key_hold[i]--;
		end
		if (pwr_hold == 0) begin
			pwr_now = ~pwr_now;
			pwr_hold = hold_len(2 * span);
		end
		pwr_hold--;
	endfunction

	// offer one tick word and wait until it is taken
	task automatic send_word(input logic [2:0] lv, input logic pl);
		in_valid <= 1'b1;
		key_levels <= lv;
		power_level <= pl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop sending and let every expected word come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (event_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kdrl_pkg::CFG_IDX_W-1:0] idx,
			input logic [kdrl_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		kdrl_pkg::CFG_LOCKOUT:      tmg.lockout = data;
		kdrl_pkg::CFG_CONFIRM:      tmg.confirm = data;
		kdrl_pkg::CFG_REPEAT_START: tmg.repeat_start = data;
		kdrl_pkg::CFG_REPEAT_INT:   tmg.repeat_int = data;
		kdrl_pkg::CFG_LONG_PRESS:   tmg.long_press = data;
		kdrl_pkg::CFG_REPEAT_MASK:  rep_en = data[2:0];
		kdrl_pkg::CFG_RELEASE_MASK: rel_en = data[2:0];
		default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// program a full register set, then stream random level words in bursts
	task automatic run_phase(input kdrl_pkg::timing_t t, input logic [2:0] rm,
			input logic [2:0] relm, input int n, input int span);
		int burst;
		int gap;
		wait_idle();
		write_reg(kdrl_pkg::CFG_LOCKOUT, t.lockout);
		write_reg(kdrl_pkg::CFG_CONFIRM, t.confirm);
		write_reg(kdrl_pkg::CFG_REPEAT_START, t.repeat_start);
		write_reg(kdrl_pkg::CFG_REPEAT_INT, t.repeat_int);
		write_reg(kdrl_pkg::CFG_LONG_PRESS, t.long_press);
		write_reg(kdrl_pkg::CFG_REPEAT_MASK, {13'($urandom), rm});
		write_reg(kdrl_pkg::CFG_RELEASE_MASK, {13'($urandom), relm});
		burst = $urandom_range(1, 40);
		for (int k = 0; k < n; k++) begin
			advance_levels(span);
			send_word(lvl_now, pwr_now);
			event_q.push_back(debounce_tick(lvl_now, pwr_now));
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// result side: check each word, stall on a pattern of its own
	int rx_mode = 0;
	int rx_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	event_word_t got;
	event_word_t want;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got = '{press_events, release_events, power_short, power_long};
			words_seen++;
			if (event_q.size() == 0) begin
				errors++;
				$display("%0t: expected no word, got press %b release %b short %b long %b",
					$time, got.press, got.rel, got.pshort, got.plong);
			end else begin
				want = event_q.pop_front();
				if (got !== want) begin
					errors++;
					$display(
						"%0t: expected %b %b %b %b got %b %b %b %b (press release short long)",
						$time, want.press, want.rel, want.pshort, want.plong,
						got.press, got.rel, got.pshort, got.plong);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && words_seen >= 300) begin
			// long hold-off so the output register fills and input stalls
			hold_done = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(8, 64);
			end
			rx_left--;
			case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (rx_left % 3 == 0);
			endcase
		end
	end

	// watchdog on cycles with no word moving anywhere
	int quiet = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		kdrl_pkg::timing_t t;
		event_word_t pred;

		// predictor at reset
		tmg = '{kdrl_pkg::LOCKOUT_RST, kdrl_pkg::CONFIRM_RST, kdrl_pkg::REPEAT_START_RST,
			kdrl_pkg::REPEAT_INT_RST, kdrl_pkg::LONG_PRESS_RST};
		rep_en = kdrl_pkg::REPEAT_MASK_RST;
		rel_en = kdrl_pkg::RELEASE_MASK_RST;
		for (int i = 0; i < 3; i++) begin
			key_stage[i] = K_IDLE;
			key_count[i] = '0;
			press_age[i] = 16'hffff;
			key_last[i] = 1'b1;
		end
		pwr_stage = P_WAIT_REL;
		pwr_count = '0;
		long_fired = 1'b0;

		// under reset timing nothing can fire within the first ticks
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b1, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b000, 1'b0, 1'b1, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b1, 1'b1, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b000, 1'b1, 1'b1, 8'h00});
		// zero confirm and repeat interval, repeat mask with junk upper bits, bad index
		dir_rows.push_back('{ROW_CFG, kdrl_pkg::CFG_CONFIRM, 16'd0, 3'b000, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_CFG, kdrl_pkg::CFG_LOCKOUT, 16'd3, 3'b000, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_CFG, kdrl_pkg::CFG_REPEAT_START, 16'd2, 3'b000, 1'b1, 1'b0,
			8'h00});
		dir_rows.push_back('{ROW_CFG, kdrl_pkg::CFG_REPEAT_INT, 16'd0, 3'b000, 1'b1, 1'b0,
			8'h00});
		dir_rows.push_back('{ROW_CFG, kdrl_pkg::CFG_LONG_PRESS, 16'd4, 3'b000, 1'b1, 1'b0,
			8'h00});
		dir_rows.push_back('{ROW_CFG, kdrl_pkg::CFG_REPEAT_MASK, 16'hfff9, 3'b000, 1'b1, 1'b0,
			8'h00});
		dir_rows.push_back('{ROW_CFG, kdrl_pkg::CFG_RELEASE_MASK, 16'h0006, 3'b000, 1'b1, 1'b0,
			8'h00});
		dir_rows.push_back('{ROW_CFG, CFG_NONE, 16'hffff, 3'b000, 1'b1, 1'b0, 8'h00});
		// press, repeats, release, lockout, release without enable, rise in confirm
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b000, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b000, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b000, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b010, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b110, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b110, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b011, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		// power key: release after a long press, then a press whose level bounces back in debounce
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back('{ROW_TICK, 3'd0, 16'd0, 3'b111, 1'b0, 1'b0, 8'h00});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				send_word(dir_rows[r].keys, dir_rows[r].pwr);
				pred = debounce_tick(dir_rows[r].keys, dir_rows[r].pwr);
				event_q.push_back(dir_rows[r].typed ? dir_rows[r].want : pred);
			end
		end
		lvl_now = 3'b111;
		pwr_now = 1'b0;

		// small random timing, random enable masks
		for (int p = 0; p < 4; p++) begin
			t.lockout = 16'($urandom_range(0, 6));
			t.confirm = 16'($urandom_range(0, 4));
			t.repeat_start = 16'($urandom_range(0, 8));
			t.repeat_int = 16'($urandom_range(0, 4));
			t.long_press = 16'($urandom_range(0, 14));
			run_phase(t, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 200, 12);
		end
		// all registers at zero
		t = '0;
		run_phase(t, 3'b000, 3'b000, 100, 6);
		// all registers at maximum
		t = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
		run_phase(t, 3'b111, 3'b111, 60, 30);
		// reset timing with long holds
		t = '{kdrl_pkg::LOCKOUT_RST, kdrl_pkg::CONFIRM_RST, kdrl_pkg::REPEAT_START_RST,
			kdrl_pkg::REPEAT_INT_RST, kdrl_pkg::LONG_PRESS_RST};
		run_phase(t, kdrl_pkg::REPEAT_MASK_RST, kdrl_pkg::RELEASE_MASK_RST, 240, 300);
		// everything enabled, short timing
		t = '{16'd2, 16'd1, 16'd3, 16'd1, 16'd6};
		run_phase(t, 3'b111, 3'b111, 100, 10);

		wait_idle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

`default_nettype wire
